/* rtl/prl_pkg.sv */
// Package for the peer rate limiter: widths, register indexes, deny codes,
// and the structures passed between the front and back parts. No dependencies.
`default_nettype none
package prl_pkg;
    localparam int PEER_COUNT_DEF    = 16;
    localparam int HISTORY_DEPTH_DEF = 50;
    localparam int HASH_W  = 64;
    localparam int COUNT_W = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_MUL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MID_MUL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_MUL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_LIM = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN  = 3'd6;

    localparam logic [1:0] CAUSE_OK    = 2'd0;
    localparam logic [1:0] CAUSE_LIMIT = 2'd1;
    localparam logic [1:0] CAUSE_DUP   = 2'd2;

    typedef struct packed {
        logic [3:0]         peer;
        logic [HASH_W-1:0]  hash;
        logic [31:0]        tick;
        logic [COUNT_W-1:0] limit;
    } msg_t;
endpackage
`default_nettype wire

/* rtl/peer_rate_limiter_with_dedup.sv */
// Top level of the peer rate limiter with duplicate rejection.
// Depends on prl_pkg, prl_front and prl_back.
// Payload items are taken one per cycle while hashing; no new message starts
// while the queue still holds the previous one. A last item blocks the input
// while the limit is multiplied and the message waits in the queue. The back
// part checks window and limit, then compares each stored hash in turn via
// the single read port of the history memory. A one-entry queue between the
// two parts lets the next message hash while the previous one is searched.
`default_nettype none
module peer_rate_limiter_with_dedup
#(
    parameter int PEER_COUNT    = prl_pkg::PEER_COUNT_DEF,
    parameter int HISTORY_DEPTH = prl_pkg::HISTORY_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // peer_index[3:0], reputation[35:4], has_topic_limit[36], topic_limit[52:37],
    // current_tick[84:53], payload_byte[92:85], has_byte[93]
    input  wire logic [95:0] s_tdata,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // allowed[0], deny_cause[2:1]
    output logic [7:0]       m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    logic signed [31:0] low_thr_reg, high_thr_reg;
    logic [15:0] low_mul_reg, mid_mul_reg, high_mul_reg, base_lim_reg;
    logic [31:0] win_len_reg;
    logic          qv, qr;
    prl_pkg::msg_t qd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg  <= 32'sd0;
            high_thr_reg <= 32'sd65536;
            low_mul_reg  <= 16'd128;
            mid_mul_reg  <= 16'd256;
            high_mul_reg <= 16'd512;
            base_lim_reg <= 16'd100;
            win_len_reg  <= 32'd1000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                prl_pkg::REG_LOW_THR:  low_thr_reg  <= cfg_data;
                prl_pkg::REG_HIGH_THR: high_thr_reg <= cfg_data;
                prl_pkg::REG_LOW_MUL:  low_mul_reg  <= cfg_data[15:0];
                prl_pkg::REG_MID_MUL:  mid_mul_reg  <= cfg_data[15:0];
                prl_pkg::REG_HIGH_MUL: high_mul_reg <= cfg_data[15:0];
                prl_pkg::REG_BASE_LIM: base_lim_reg <= cfg_data[15:0];
                prl_pkg::REG_WIN_LEN:  win_len_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    prl_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .peer_index(s_tdata[3:0]), .reputation(s_tdata[35:4]),
        .has_topic_limit(s_tdata[36]), .topic_limit(s_tdata[52:37]),
        .current_tick(s_tdata[84:53]), .payload_byte(s_tdata[92:85]),
        .has_byte(s_tdata[93]), .last_byte(s_tlast),
        .low_threshold(low_thr_reg), .high_threshold(high_thr_reg),
        .low_multiplier(low_mul_reg), .mid_multiplier(mid_mul_reg),
        .high_multiplier(high_mul_reg), .base_limit(base_lim_reg),
        .q_valid(qv), .q_ready(qr), .q_data(qd)
    );

    prl_back #(.PEER_COUNT(PEER_COUNT), .HISTORY_DEPTH(HISTORY_DEPTH)) u_back
    (
        .clk(clk), .rst_n(rst_n), .q_valid(qv), .q_ready(qr), .q_data(qd),
        .window_length(win_len_reg), .out_valid(m_tvalid), .out_ready(m_tready),
        .out_data(m_tdata)
    );
endmodule
`default_nettype wire

/* rtl/prl_front.sv */
// Front part: byte hashing, reputation multiplier select and limit scaling.
// Depends on prl_pkg. Emits one msg_t per message into the queue.
`default_nettype none
module prl_front
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [3:0]           peer_index,
    input  wire logic signed [31:0]   reputation,
    input  wire logic                 has_topic_limit,
    input  wire logic [15:0]          topic_limit,
    input  wire logic [31:0]          current_tick,
    input  wire logic [7:0]           payload_byte,
    input  wire logic                 has_byte,
    input  wire logic                 last_byte,
    input  wire logic signed [31:0]   low_threshold,
    input  wire logic signed [31:0]   high_threshold,
    input  wire logic [15:0]          low_multiplier,
    input  wire logic [15:0]          mid_multiplier,
    input  wire logic [15:0]          high_multiplier,
    input  wire logic [15:0]          base_limit,
    output logic                      q_valid,
    input  wire logic                 q_ready,
    output prl_pkg::msg_t             q_data
);
    logic [prl_pkg::HASH_W-1:0] hash_reg, hash_next;
    logic                       busy_reg;
    logic [15:0]                mul_reg, lim_reg;
    prl_pkg::msg_t              hold_reg;
    logic                       qv_reg;
    logic [31:0]                prod;
    logic [23:0]                scaled;

    assign in_ready = !busy_reg && !qv_reg;
    assign hash_next = has_byte ? (hash_reg * 64'd131 + {56'd0, payload_byte}) : hash_reg;
    assign prod = lim_reg * mul_reg;
    assign scaled = prod[31:8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= '0;
            busy_reg <= 1'b0;
            qv_reg   <= 1'b0;
        end
        else
        begin
            if (qv_reg && q_ready)
                qv_reg <= 1'b0;
            if (busy_reg)
            begin
                busy_reg <= 1'b0;
                qv_reg   <= 1'b1;
                hold_reg.limit <= (scaled == 24'd0) ? 24'd1 : scaled;
            end
            if (in_valid && in_ready)
            begin
                if (last_byte)
                begin
                    hash_reg <= '0;
                    busy_reg <= 1'b1;
                    hold_reg.peer <= peer_index;
                    hold_reg.hash <= hash_next;
                    hold_reg.tick <= current_tick;
                    lim_reg <= has_topic_limit ? topic_limit : base_limit;
                    if (reputation < low_threshold)
                        mul_reg <= low_multiplier;
                    else if (reputation >= high_threshold)
                        mul_reg <= high_multiplier;
                    else
                        mul_reg <= mid_multiplier;
                end
                else
                    hash_reg <= hash_next;
            end
        end
    end

    assign q_valid = qv_reg;
    assign q_data  = hold_reg;
endmodule
`default_nettype wire

/* rtl/prl_back.sv */
// Back part: per-peer window and count, history search over the hash memory.
// Depends on prl_pkg. Takes msg_t from the front, produces the decision.
`default_nettype none
module prl_back
#(
    parameter int PEER_COUNT    = prl_pkg::PEER_COUNT_DEF,
    parameter int HISTORY_DEPTH = prl_pkg::HISTORY_DEPTH_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire prl_pkg::msg_t q_data,
    input  wire logic [31:0]   window_length,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_data
);
    localparam int PW = (PEER_COUNT > 1) ? $clog2(PEER_COUNT) : 1;
    localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam int MD = PEER_COUNT * HISTORY_DEPTH;
    localparam int AW = (MD > 1) ? $clog2(MD) : 1;
    localparam logic [2:0] S_IDLE = 3'd0, S_CHECK = 3'd1, S_READ = 3'd2,
                           S_CMP = 3'd3, S_DONE = 3'd4;

    logic [2:0]  state_reg;
    logic [31:0] wstart_reg [PEER_COUNT];
    logic [prl_pkg::COUNT_W-1:0] count_reg [PEER_COUNT];
    logic [FW-1:0] fill_reg [PEER_COUNT];
    logic [HW-1:0] head_reg [PEER_COUNT];
    logic [prl_pkg::HASH_W-1:0] mem [MD];
    logic [prl_pkg::HASH_W-1:0] rd_reg;
    prl_pkg::msg_t m_reg;
    logic [PW-1:0] p_reg;
    logic [FW-1:0] i_reg;
    logic [31:0]   ws;
    logic [prl_pkg::COUNT_W-1:0] cnt;
    logic [FW-1:0] fil;
    logic          restart;
    logic [AW-1:0] base_addr;
    logic          ov_reg;
    logic [1:0]    cause_reg;
    logic [PW-1:0] pin;
    logic          done_go;

    assign pin = (32'(q_data.peer) >= 32'(PEER_COUNT)) ? PW'(PEER_COUNT - 1) : PW'(q_data.peer);
    assign ws  = wstart_reg[p_reg];
    assign restart = (ws == 32'd0) || ({1'b0, m_reg.tick} >= ({1'b0, ws} + {1'b0, window_length}));
    assign cnt = restart ? '0 : count_reg[p_reg];
    assign fil = restart ? '0 : fill_reg[p_reg];
    assign base_addr = AW'(32'(p_reg) * HISTORY_DEPTH);
    assign q_ready = (state_reg == S_IDLE);
    assign done_go = (state_reg == S_DONE) && (!ov_reg || out_ready);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
            rd_reg <= mem[base_addr + AW'(i_reg)];
        if (state_reg == S_DONE && cause_reg == prl_pkg::CAUSE_OK)
            mem[base_addr + AW'(head_reg[p_reg])] <= m_reg.hash;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            for (int k = 0; k < PEER_COUNT; k++)
            begin
                wstart_reg[k] <= '0;
                count_reg[k]  <= '0;
                fill_reg[k]   <= '0;
                head_reg[k]   <= '0;
            end
        end
        else
        begin
            ov_reg <= done_go || (ov_reg && !out_ready);
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        m_reg <= q_data;
                        p_reg <= pin;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (restart)
                    begin
                        wstart_reg[p_reg] <= m_reg.tick;
                        count_reg[p_reg]  <= '0;
                        fill_reg[p_reg]   <= '0;
                        head_reg[p_reg]   <= '0;
                    end
                    i_reg <= '0;
                    if (cnt >= m_reg.limit)
                    begin
                        cause_reg <= prl_pkg::CAUSE_LIMIT;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cause_reg <= prl_pkg::CAUSE_OK;
                        state_reg <= (fil == '0) ? S_DONE : S_READ;
                    end
                end
                S_READ:
                    state_reg <= S_CMP;
                S_CMP:
                begin
                    if (rd_reg == m_reg.hash)
                    begin
                        cause_reg <= prl_pkg::CAUSE_DUP;
                        state_reg <= S_DONE;
                    end
                    else if (i_reg + 1'b1 >= fill_reg[p_reg])
                        state_reg <= S_DONE;
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_DONE:
                begin
                    if (done_go)
                    begin
                        if (cause_reg == prl_pkg::CAUSE_OK)
                        begin
                            head_reg[p_reg] <= (32'(head_reg[p_reg]) + 1 >= HISTORY_DEPTH)
                                               ? '0 : head_reg[p_reg] + 1'b1;
                            if (32'(fill_reg[p_reg]) < HISTORY_DEPTH)
                                fill_reg[p_reg] <= fill_reg[p_reg] + 1'b1;
                            if (count_reg[p_reg] != {prl_pkg::COUNT_W{1'b1}})
                                count_reg[p_reg] <= count_reg[p_reg] + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_go)
            out_data <= {5'd0, cause_reg, cause_reg == prl_pkg::CAUSE_OK};
    end

    assign out_valid = ov_reg;
endmodule
`default_nettype wire

/* rtl/prl_checker.sv */
// Port-level checker for the peer rate limiter, bound to the top level.
// Depends on prl_pkg and the top level's ports.
`default_nettype none
module prl_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       cfg_ready
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == prl_pkg::CAUSE_OK))
                     && m_tdata[2:1] <= prl_pkg::CAUSE_DUP)
        else $error("allowed and cause disagree");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:3] == 5'd0)
        else $error("padding not zero");
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port stalled");
endmodule

bind peer_rate_limiter_with_dedup prl_checker u_chk
(
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .cfg_ready(cfg_ready)
);
`default_nettype wire
